FILE: hw/rtl/pbs_pkg.sv
// Shared types and constants for the partition split block.
`default_nettype none

package pbs_pkg;

  localparam int STATE_W = 10;
  localparam int ID_W    = 10;
  localparam int TOTAL_W = 11;
  localparam int CFG_W   = 11;
  localparam int EPOCH_W = 8;

  typedef enum logic [2:0] {
    FUNC_START   = 3'd0,
    FUNC_MARK    = 3'd1,
    FUNC_END_SET = 3'd2,
    FUNC_FINISH  = 3'd3,
    FUNC_READ    = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ALU_PASS = 2'd0,
    ALU_DEC  = 2'd1,
    ALU_INC  = 2'd2
  } alu_op_t;

  typedef struct packed {
    logic [2:0]         func;
    logic [STATE_W-1:0] first_state;
    logic [STATE_W-1:0] last_state;
  } cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]    block_id;
    logic [TOTAL_W-1:0] block_total;
    logic               status;
  } res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pbs_ram #(
  parameter int DW = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/pbs_alu.sv
// Shared block-size unit: saturating increment, floor-at-zero decrement, zero test.
`default_nettype none

module pbs_alu #(
  parameter int MAX_STATES = 1024,
  localparam int SW = $clog2(MAX_STATES) + 1
) (
  input  wire pbs_pkg::alu_op_t op,
  input  wire logic [SW-1:0]    a,
  output logic      [SW-1:0]    y,
  output logic                  zero
);

  always_comb begin
    case (op)
      pbs_pkg::ALU_DEC: y = (a == '0) ? a : a - 1'b1;
      pbs_pkg::ALU_INC: y = (a >= SW'(MAX_STATES)) ? a : a + 1'b1;
      default:          y = a;
    endcase
  end

  assign zero = (y == '0);

endmodule

`default_nettype wire

FILE: hw/rtl/pbs_ctrl.sv
// Sequencer and table memories for partition refinement.
`default_nettype none

module pbs_ctrl #(
  parameter int MAX_STATES = 1024,
  localparam int SW = $clog2(MAX_STATES) + 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [SW-1:0] cnt,
  input  wire logic          cmd_valid,
  output logic               cmd_ready,
  input  wire pbs_pkg::cmd_t cmd,
  output logic               res_valid,
  input  wire logic          res_ready,
  output pbs_pkg::res_t      res
);

  localparam int IW = SW - 1;
  localparam int EW = pbs_pkg::EPOCH_W;
  localparam int RW = EW + IW;
  localparam int CW = (SW > pbs_pkg::STATE_W) ? SW : pbs_pkg::STATE_W;
  localparam logic [IW-1:0] LAST_ADDR = IW'(MAX_STATES - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SWEEP, S_RD, S_MK_B, S_MK_DECIDE, S_MK_SCAN, S_MK_APPLY, S_MK_INC,
    S_FN_B, S_FN_MAP, S_FN_INC, S_CLR, S_RESP
  } state_t;

  typedef enum logic [1:0] {
    SW_RESET, SW_START, SW_FINISH, SW_REMAP
  } sweep_t;

  state_t        state;
  sweep_t        sweep_kind;
  logic [IW-1:0] sweep_addr;
  logic [EW-1:0] epoch;
  logic [IW-1:0] cur;
  logic [IW-1:0] last_r;
  logic [IW-1:0] b_r;
  logic [IW-1:0] t;
  logic [IW-1:0] j;
  logic [IW-1:0] low;
  logic [SW-1:0] n;
  logic [SW-1:0] szb_r;
  logic [SW-1:0] szb_dec;
  logic          newt;
  logic [IW-1:0] res_id;
  logic [SW-1:0] res_total;
  logic          res_status;

  logic          bos_we;
  logic [IW-1:0] bos_waddr, bos_wdata, bos_raddr, bos_rdata;
  logic          size_we;
  logic [IW-1:0] size_waddr, size_raddr;
  logic [SW-1:0] size_wdata, size_rdata;
  logic          remap_we;
  logic [IW-1:0] remap_waddr, remap_raddr;
  logic [RW-1:0] remap_wdata, remap_rdata;

  pbs_pkg::alu_op_t alu_op;
  logic [SW-1:0]    alu_a, alu_y;
  logic             alu_zero;

  logic          remap_hit;
  logic [IW-1:0] remap_tgt;
  logic [IW-1:0] fn_id;
  logic          bad_mark, bad_read;

  assign remap_hit = (remap_rdata[IW +: EW] == epoch);
  assign remap_tgt = remap_rdata[IW-1:0];
  assign fn_id     = remap_hit ? remap_tgt : IW'(n);

  assign bad_mark = (cmd.first_state > cmd.last_state) || (CW'(cmd.last_state) >= CW'(cnt));
  assign bad_read = (CW'(cmd.first_state) >= CW'(cnt));

  assign cmd_ready = (state == S_IDLE);
  assign res_valid = (state == S_RESP);
  assign res.block_id    = pbs_pkg::ID_W'(res_id);
  assign res.block_total = pbs_pkg::TOTAL_W'(res_total);
  assign res.status      = res_status;

  pbs_ram #(.DW(IW), .DEPTH(MAX_STATES)) u_bos_ram (
    .clk(clk), .we(bos_we), .waddr(bos_waddr), .wdata(bos_wdata),
    .raddr(bos_raddr), .rdata(bos_rdata)
  );

  pbs_ram #(.DW(SW), .DEPTH(MAX_STATES)) u_size_ram (
    .clk(clk), .we(size_we), .waddr(size_waddr), .wdata(size_wdata),
    .raddr(size_raddr), .rdata(size_rdata)
  );

  pbs_ram #(.DW(RW), .DEPTH(MAX_STATES)) u_remap_ram (
    .clk(clk), .we(remap_we), .waddr(remap_waddr), .wdata(remap_wdata),
    .raddr(remap_raddr), .rdata(remap_rdata)
  );

  pbs_alu #(.MAX_STATES(MAX_STATES)) u_alu (
    .op(alu_op), .a(alu_a), .y(alu_y), .zero(alu_zero)
  );

  always_comb begin
    bos_we      = 1'b0;
    bos_waddr   = cur;
    bos_wdata   = t;
    bos_raddr   = cur;
    size_we     = 1'b0;
    size_waddr  = b_r;
    size_wdata  = alu_y;
    size_raddr  = j;
    remap_we    = 1'b0;
    remap_waddr = b_r;
    remap_wdata = {epoch, t};
    remap_raddr = b_r;
    alu_op      = pbs_pkg::ALU_PASS;
    alu_a       = size_rdata;
    case (state)
      S_IDLE: begin
        bos_raddr = IW'(cmd.first_state);
      end
      S_SWEEP: begin
        bos_raddr   = '0;
        bos_we      = (sweep_kind == SW_RESET) || (sweep_kind == SW_START);
        bos_waddr   = sweep_addr;
        bos_wdata   = '0;
        size_we     = (sweep_kind != SW_REMAP);
        size_waddr  = sweep_addr;
        size_wdata  = ((sweep_kind == SW_START) && (sweep_addr == '0)) ? cnt : '0;
        remap_we    = 1'b1;
        remap_waddr = sweep_addr;
        remap_wdata = '0;
      end
      S_MK_B: begin
        size_raddr  = bos_rdata;
        remap_raddr = bos_rdata;
      end
      S_MK_DECIDE: begin
        size_raddr = low;
      end
      S_MK_SCAN: begin
        size_raddr = j + 1'b1;
      end
      S_MK_APPLY: begin
        alu_op     = pbs_pkg::ALU_DEC;
        alu_a      = szb_r;
        size_we    = 1'b1;
        size_waddr = b_r;
        bos_we     = 1'b1;
        remap_we   = newt;
        size_raddr = t;
      end
      S_MK_INC: begin
        alu_op     = pbs_pkg::ALU_INC;
        alu_a      = (t == b_r) ? szb_dec : size_rdata;
        size_we    = 1'b1;
        size_waddr = t;
        bos_raddr  = cur + 1'b1;
      end
      S_FN_B: begin
        remap_raddr = bos_rdata;
      end
      S_FN_MAP: begin
        bos_we      = 1'b1;
        bos_wdata   = fn_id;
        remap_we    = !remap_hit;
        remap_wdata = {epoch, fn_id};
        size_raddr  = fn_id;
      end
      S_FN_INC: begin
        alu_op     = pbs_pkg::ALU_INC;
        size_we    = 1'b1;
        size_waddr = t;
        bos_raddr  = cur + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      sweep_kind <= SW_RESET;
      sweep_addr <= '0;
      epoch      <= '0;
      low        <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            res_id     <= '0;
            res_total  <= '0;
            res_status <= 1'b0;
            cur        <= IW'(cmd.first_state);
            last_r     <= IW'(cmd.last_state);
            case (cmd.func)
              pbs_pkg::FUNC_START: begin
                sweep_kind <= SW_START;
                sweep_addr <= '0;
                state      <= S_SWEEP;
              end
              pbs_pkg::FUNC_MARK: begin
                if (bad_mark) begin
                  res_status <= 1'b1;
                  state      <= S_RESP;
                end else begin
                  state <= S_MK_B;
                end
              end
              pbs_pkg::FUNC_END_SET: state <= S_CLR;
              pbs_pkg::FUNC_FINISH: begin
                sweep_kind <= SW_FINISH;
                sweep_addr <= '0;
                state      <= S_SWEEP;
              end
              pbs_pkg::FUNC_READ: begin
                if (bad_read) begin
                  res_status <= 1'b1;
                  state      <= S_RESP;
                end else begin
                  state <= S_RD;
                end
              end
              default: state <= S_RESP;
            endcase
          end
        end
        S_SWEEP: begin
          sweep_addr <= sweep_addr + 1'b1;
          if (sweep_addr == LAST_ADDR) begin
            epoch <= EW'(1);
            low   <= '0;
            n     <= '0;
            cur   <= '0;
            case (sweep_kind)
              SW_RESET:  state <= S_IDLE;
              SW_FINISH: state <= (cnt == '0) ? S_CLR : S_FN_B;
              default:   state <= S_RESP;
            endcase
          end
        end
        S_RD: begin
          res_id <= bos_rdata;
          state  <= S_RESP;
        end
        S_MK_B: begin
          b_r   <= bos_rdata;
          state <= S_MK_DECIDE;
        end
        S_MK_DECIDE: begin
          szb_r <= size_rdata;
          if (remap_hit) begin
            t     <= remap_tgt;
            newt  <= 1'b0;
            state <= S_MK_APPLY;
          end else begin
            newt <= 1'b1;
            if (size_rdata != SW'(1)) begin
              j     <= low;
              state <= S_MK_SCAN;
            end else begin
              t     <= b_r;
              state <= S_MK_APPLY;
            end
          end
        end
        S_MK_SCAN: begin
          if (alu_zero) begin
            t     <= j;
            low   <= j;
            state <= S_MK_APPLY;
          end else if (j == LAST_ADDR) begin
            t     <= b_r;
            state <= S_MK_APPLY;
          end else begin
            j <= j + 1'b1;
          end
        end
        S_MK_APPLY: begin
          szb_dec <= alu_y;
          if (alu_zero && (b_r < low)) begin
            low <= b_r;
          end
          state <= S_MK_INC;
        end
        S_MK_INC: begin
          if (cur == last_r) begin
            res_id <= t;
            state  <= S_RESP;
          end else begin
            cur   <= cur + 1'b1;
            state <= S_MK_B;
          end
        end
        S_FN_B: begin
          b_r   <= bos_rdata;
          state <= S_FN_MAP;
        end
        S_FN_MAP: begin
          t <= fn_id;
          if (!remap_hit) begin
            n <= n + 1'b1;
          end
          state <= S_FN_INC;
        end
        S_FN_INC: begin
          if (cur == IW'(cnt - 1'b1)) begin
            res_total <= n;
            state     <= S_CLR;
          end else begin
            cur   <= cur + 1'b1;
            state <= S_FN_B;
          end
        end
        S_CLR: begin
          if (epoch == '1) begin
            sweep_kind <= SW_REMAP;
            sweep_addr <= '0;
            state      <= S_SWEEP;
          end else begin
            epoch <= epoch + 1'b1;
            state <= S_RESP;
          end
        end
        S_RESP: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // tag 0 marks a cleared remap entry, so a live epoch is never 0
  a_epoch_live: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (epoch != '0))
    else $error("remap epoch is zero while idle");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_MK_SCAN) |-> (j >= low))
    else $error("free-block scan below lower bound");

  a_mark_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MK_B) |-> (cur <= last_r))
    else $error("mark walked past last state");

  a_dense_id: assert property (@(posedge clk) disable iff (rst)
    (state == S_FN_INC) |-> (SW'(t) < n))
    else $error("renumbered block id not below block count");

endmodule

`default_nettype wire

FILE: hw/rtl/partition_split_by_set.sv
// Top level of the partition refinement block: stream ports, config register, result register.
//
// Input stream (s_axis): one command per transfer. tuser carries the operation
// (start, mark range, end of set, finish, read), tdata the first and last state.
// Output stream (m_axis): one result per command. tdata carries the block id and
// the block total, tuser the error flag. cfg carries the state count.
// Work per command, from acceptance to the result register:
//   read: one table read; end of set: an epoch step; unknown op, rejected range: none
//   mark: table reads and size updates per marked state, and a free-block search that
//     probes size entries from a kept lower bound on the lowest empty block
//   start: a sweep over all MAX_STATES table entries, one entry per cycle
//   finish: a sweep clearing the size and remap tables, then a pass over each state in use
//   at most one in every 255 set clears also costs a remap sweep
// The sequencer owns three tables, each with one write and one read port, and
// takes one command at a time; s_axis_tready is high only when it is idle.
// After reset a sweep over all MAX_STATES entries clears the tables; no command is
// taken meanwhile, config writes are. A result waits in the output register
// while the receiver stalls, and the next command may be accepted behind it.
`default_nettype none

module partition_split_by_set #(
  parameter int MAX_STATES = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // first_state[9:0], last_state[19:10], zero pad
  input  wire logic [2:0]  s_axis_tuser,  // func[2:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [23:0] m_axis_tdata,  // block_id[9:0], block_total[20:10], zero pad
  output logic      [0:0]  m_axis_tuser,  // status[0]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [10:0] cfg_data       // state_count
);

  localparam int SW = $clog2(MAX_STATES) + 1;
  localparam int CW = (SW > pbs_pkg::CFG_W) ? SW : pbs_pkg::CFG_W;

  logic [pbs_pkg::CFG_W-1:0] state_count;
  logic [SW-1:0]             cnt;
  pbs_pkg::cmd_t             cmd;
  pbs_pkg::res_t             res;
  logic                      res_valid;
  logic                      res_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state_count <= pbs_pkg::CFG_W'(1024);
    end else if (cfg_valid && cfg_ready) begin
      state_count <= cfg_data;
    end
  end

  assign cnt = (CW'(state_count) > CW'(MAX_STATES)) ? SW'(MAX_STATES) : SW'(state_count);

  assign cmd.func        = s_axis_tuser;
  assign cmd.first_state = s_axis_tdata[9:0];
  assign cmd.last_state  = s_axis_tdata[19:10];

  pbs_ctrl #(.MAX_STATES(MAX_STATES)) u_ctrl (
    .clk(clk),
    .rst(rst),
    .cnt(cnt),
    .cmd_valid(s_axis_tvalid),
    .cmd_ready(s_axis_tready),
    .cmd(cmd),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res)
  );

  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_axis_tdata <= {3'b000, res.block_total, res.block_id};
      m_axis_tuser <= res.status;
    end
  end

endmodule

`default_nettype wire

FILE: tb/sv/partition_split_checker.sv
// Checker for partition_split_by_set: watches all channels, predicts each result and compares.
`timescale 1ns / 1ps

module partition_split_checker #(
  parameter int MAX_STATES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // first_state[9:0], last_state[19:10], zero pad
  input  logic [2:0]  s_axis_tuser,  // func[2:0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,  // block_id[9:0], block_total[20:10], zero pad
  input  logic [0:0]  m_axis_tuser,  // status[0]
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [10:0] cfg_data,
  output int          mismatch_count,
  output int          results_owed
);
  import pbs_pkg::*;

  localparam logic [TOTAL_W-1:0] NO_TARGET = {1'b1, {(TOTAL_W-1){1'b0}}};
  localparam int COUNT_AT_RESET = 1024;

  logic [ID_W-1:0]    block_of     [MAX_STATES];
  logic [TOTAL_W-1:0] block_fill   [MAX_STATES];
  logic [TOTAL_W-1:0] split_target [MAX_STATES];
  logic [CFG_W-1:0]   count_reg;
  res_t               block_result_q [$];

  function automatic void forget_targets();
    for (int i = 0; i < MAX_STATES; i++) split_target[i] = NO_TARGET;
  endfunction

  // moves one marked state; first state of a block in this set picks the target
  function automatic void move_marked(input int s);
    int src;
    int dst;
    src = block_of[s];
    if (split_target[src][TOTAL_W-1]) begin
      dst = src;
      if (block_fill[src] != 1) begin
        for (int j = 0; j < MAX_STATES; j++) begin
          if (block_fill[j] == 0) begin
            dst = j;
            break;
          end
        end
      end
      split_target[src] = dst;
    end
    dst = split_target[src];
    if (block_fill[src] != 0) block_fill[src] = block_fill[src] - 1'b1;
    block_of[s] = dst;
    if (block_fill[dst] < MAX_STATES) block_fill[dst] = block_fill[dst] + 1'b1;
  endfunction

  function automatic res_t refine_op(input logic [2:0] op, input logic [STATE_W-1:0] first,
                                     input logic [STATE_W-1:0] last);
    res_t r;
    int lim;
    int n;
    int b;
    r = '0;
    lim = (count_reg > MAX_STATES) ? MAX_STATES : count_reg;
    case (op)
      FUNC_START: begin
        for (int i = 0; i < MAX_STATES; i++) begin
          block_of[i] = '0;
          block_fill[i] = '0;
        end
        block_fill[0] = lim;
        forget_targets();
      end
      FUNC_MARK: begin
        if (first > last || last >= lim) begin
          r.status = 1'b1;
        end else begin
          for (int i = first; i <= last; i++) move_marked(i);
          r.block_id = block_of[last];
        end
      end
      FUNC_END_SET: forget_targets();
      FUNC_FINISH: begin
        n = 0;
        forget_targets();
        for (int i = 0; i < MAX_STATES; i++) block_fill[i] = '0;
        for (int i = 0; i < lim; i++) begin
          b = block_of[i];
          if (split_target[b][TOTAL_W-1]) begin
            split_target[b] = n;
            n++;
          end
          block_of[i] = split_target[b];
          block_fill[block_of[i]] = block_fill[block_of[i]] + 1'b1;
        end
        forget_targets();
        r.block_total = n;
      end
      FUNC_READ: begin
        if (first >= lim) r.status = 1'b1;
        else r.block_id = block_of[first];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int field_bad(input string field, input logic [31:0] want_v,
                                   input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, field, want_v, got_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : watch
    res_t seen;
    res_t want;
    int errs;
    errs = mismatch_count;
    if (rst) begin
      for (int i = 0; i < MAX_STATES; i++) begin
        block_of[i] = '0;
        block_fill[i] = '0;
      end
      forget_targets();
      count_reg = COUNT_AT_RESET;
      block_result_q.delete();
      errs = 0;
    end else begin
      if (cfg_valid && cfg_ready) count_reg = cfg_data;
      if (m_axis_tvalid && m_axis_tready) begin
        seen.block_id = m_axis_tdata[ID_W-1:0];
        seen.block_total = m_axis_tdata[ID_W+TOTAL_W-1:ID_W];
        seen.status = m_axis_tuser[0];
        if (block_result_q.size() == 0) begin
          $display("%0t: unexpected result block_id %0d block_total %0d status %0d",
                   $time, seen.block_id, seen.block_total, seen.status);
          errs++;
        end else begin
          want = block_result_q.pop_front();
          errs += field_bad("block_id", want.block_id, seen.block_id)
                + field_bad("block_total", want.block_total, seen.block_total)
                + field_bad("status", want.status, seen.status);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        block_result_q.push_back(refine_op(s_axis_tuser, s_axis_tdata[STATE_W-1:0],
                                           s_axis_tdata[2*STATE_W-1:STATE_W]));
    end
    mismatch_count <= errs;
    results_owed <= block_result_q.size();
  end

endmodule

FILE: tb/sv/partition_split_by_set_test.sv
// Testbench top for partition_split_by_set: clock, reset, stimulus, backpressure and verdict.
`timescale 1ns / 1ps

module partition_split_by_set_test;
  import pbs_pkg::*;

  localparam int MAX_STATES = 1024;
  localparam int CYCLE_LIMIT = 3000000;
  localparam logic [2:0] OP_RESERVED_LO = 3'd5;
  localparam logic [2:0] OP_RESERVED_HI = 3'd7;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 100;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // first_state[9:0], last_state[19:10], zero pad
  logic [2:0]  s_axis_tuser = '0;  // func[2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;       // block_id[9:0], block_total[20:10], zero pad
  logic [0:0]  m_axis_tuser;       // status[0]
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [10:0] cfg_data = '0;

  int fail_count;
  int open_count;
  int cycle_count = 0;
  int items_sent = 0;
  int cur_count = 1024;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  int rx_hold = 0;
  int rx_stretch = 0;
  int rx_pick;

  partition_split_by_set #(.MAX_STATES(MAX_STATES)) u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  partition_split_checker #(.MAX_STATES(MAX_STATES)) u_check (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .mismatch_count(fail_count), .results_owed(open_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: random stalls, mostly short, a few long, with calm stretches
  always @(posedge clk) begin
    if (rx_stretch == 0) begin
      rx_stretch <= $urandom_range(40, 400);
      rx_calm <= ($urandom_range(0, 3) == 0);
    end else begin
      rx_stretch <= rx_stretch - 1;
    end
    if (rx_hold != 0) begin
      m_axis_tready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else if (rx_calm) begin
      m_axis_tready <= 1'b1;
    end else begin
      rx_pick = $urandom_range(0, 99);
      if (rx_pick < 60) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        if (rx_pick < 90) rx_hold <= $urandom_range(0, 2);
        else if (rx_pick < 98) rx_hold <= $urandom_range(3, 10);
        else rx_hold <= $urandom_range(20, 60);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tx_calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  task automatic pause(input int n);
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic issue(input logic [2:0] op, input logic [9:0] first, input logic [9:0] last);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {4'b0, last, first};
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    if (items_sent % 40 == 0) tx_calm = ($urandom_range(0, 3) == 0);
    pause(pick_gap());
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (open_count != 0);
  endtask

  task automatic set_count(input logic [10:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_count = v;
  endtask

  task automatic random_item();
    int lim;
    int pick;
    int span;
    logic [2:0] op;
    logic [9:0] a;
    logic [9:0] b;
    lim = (cur_count > MAX_STATES) ? MAX_STATES : cur_count;
    pick = $urandom_range(0, 99);
    a = $urandom;
    b = $urandom;
    if (pick < 4) begin
      op = FUNC_START;
    end else if (pick < 58) begin
      op = FUNC_MARK;
      if (lim > 0 && $urandom_range(0, 9) != 0) begin
        a = $urandom_range(0, lim - 1);
        span = ($urandom_range(0, 19) == 0) ? $urandom_range(0, lim - 1 - a)
                                             : $urandom_range(0, 7);
        b = (a + span >= lim) ? lim - 1 : a + span;
      end
    end else if (pick < 70) begin
      op = FUNC_END_SET;
    end else if (pick < 75) begin
      op = FUNC_FINISH;
    end else if (pick < 92) begin
      op = FUNC_READ;
      if (lim > 0 && $urandom_range(0, 6) != 0) a = $urandom_range(0, lim - 1);
    end else if (pick < 96) begin
      op = $urandom_range(OP_RESERVED_LO, OP_RESERVED_HI);
    end else begin
      op = $urandom;
    end
    issue(op, a, b);
  endtask

  initial begin : stimulus
    logic [10:0] phase_count [PHASES];
    phase_count[0] = 11'd1;
    phase_count[1] = 11'd0;
    phase_count[2] = 11'd1024;
    phase_count[3] = 11'd2;
    phase_count[4] = 11'd2047;
    phase_count[5] = $urandom_range(3, 40);
    phase_count[6] = $urandom_range(3, 64);
    phase_count[7] = $urandom_range(65, 1023);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // marks and reads before any start, then unused operation codes
    issue(FUNC_MARK, 10'd5, 10'd9);
    issue(FUNC_READ, 10'd7, 10'd0);
    issue(OP_RESERVED_LO, 10'h3FF, 10'h3FF);
    issue(OP_RESERVED_LO + 3'd1, 10'h155, 10'h2AA);
    issue(OP_RESERVED_HI, 10'd0, 10'd0);
    issue(FUNC_START, 10'd0, 10'd0);
    issue(FUNC_READ, 10'd1023, 10'd0);
    issue(FUNC_MARK, 10'd0, 10'd0);
    issue(FUNC_MARK, 10'd1023, 10'd1023);
    issue(FUNC_MARK, 10'd10, 10'd5);
    issue(FUNC_MARK, 10'd0, 10'd1023);
    issue(FUNC_END_SET, 10'd0, 10'd0);
    issue(FUNC_MARK, 10'd3, 10'd7);
    issue(FUNC_MARK, 10'd500, 10'd520);
    issue(FUNC_FINISH, 10'd0, 10'd0);  // finish while a set is open
    issue(FUNC_READ, 10'd520, 10'd0);
    issue(FUNC_MARK, 10'd1, 10'd1);
    issue(FUNC_END_SET, 10'd0, 10'd0);
    issue(FUNC_FINISH, 10'd0, 10'd0);
    // shrink the count mid-session: out-of-range index, range past the end
    drain_results();
    set_count(11'd16);
    issue(FUNC_READ, 10'd16, 10'd0);
    issue(FUNC_MARK, 10'd4, 10'd16);
    issue(FUNC_MARK, 10'd2, 10'd9);
    issue(FUNC_FINISH, 10'd0, 10'd0);
    drain_results();
    set_count(11'd1024);
    issue(FUNC_READ, 10'd1000, 10'd0);
    issue(FUNC_MARK, 10'd900, 10'd900);

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      set_count(phase_count[p]);
      repeat (ITEMS_PER_PHASE) random_item();
    end

    drain_results();
    repeat (16) @(posedge clk);
    if (fail_count == 0 && open_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/pbs_pkg.sv
hw/rtl/pbs_ram.sv
hw/rtl/pbs_alu.sv
hw/rtl/pbs_ctrl.sv
hw/rtl/partition_split_by_set.sv
tb/sv/partition_split_checker.sv
tb/sv/partition_split_by_set_test.sv
